// File: rtl/lupp_pkg.sv
// Package for the LU decomposition core: sizes, command and result types,
// controller state encoding and the saturating fixed-point helpers.
// Depends on nothing; lupp_div and the core take names from here (lupp_ram does not).
package lupp_pkg;

  localparam int MAX_ORDER = 8;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int ELEM_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int NUM_W     = ELEM_W + FRAC_W;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ORDER_W   = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

  typedef enum logic [1:0] {
    FUNC_WRITE,
    FUNC_FACTOR,
    FUNC_READ,
    FUNC_PERM
  } func_t;

  typedef struct packed {
    func_t                    func;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;
  } cmd_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] read_value;
    logic                     singular_flag;
    logic                     overflow_flag;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_WAIT,
    S_DONE,
    S_F_INIT,
    S_PS_ADDR,
    S_PS_CMP,
    S_SW_RA,
    S_SW_RB,
    S_SW_W1,
    S_SW_W2,
    S_PM1,
    S_PM2,
    S_PIV,
    S_ZERO,
    S_NEXT_K,
    S_E_RD,
    S_E_DIV,
    S_E_WAIT,
    S_M_RA,
    S_M_RB,
    S_M_SAT,
    S_M_WR
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [ELEM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     ovf;
  } sat_t;

  function automatic logic [ELEM_W-1:0] magnitude(input logic signed [ELEM_W-1:0] v);
    logic [ELEM_W-1:0] u;
    u = v;
    return u[ELEM_W-1] ? (~u + ELEM_W'(1)) : u;
  endfunction

  // Rebuilds a signed element from sign and magnitude, clamping at the limits.
  function automatic sat_t from_mag(input logic neg, input logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0]  limit;
    logic [ELEM_W-1:0] m;
    sat_t              r;
    limit = neg ? (NUM_W'(1) << (ELEM_W - 1)) : ((NUM_W'(1) << (ELEM_W - 1)) - NUM_W'(1));
    r.ovf = mag > limit;
    m = r.ovf ? limit[ELEM_W-1:0] : mag[ELEM_W-1:0];
    r.value = neg ? (~m + ELEM_W'(1)) : m;
    return r;
  endfunction

  function automatic sat_t sat_sub(input logic signed [ELEM_W-1:0] a,
                                   input logic signed [ELEM_W-1:0] b);
    logic signed [ELEM_W:0] d;
    sat_t                   r;
    d = {a[ELEM_W-1], a} - {b[ELEM_W-1], b};
    r.ovf = d[ELEM_W] != d[ELEM_W-1];
    if (!r.ovf) begin
      r.value = d[ELEM_W-1:0];
    end else if (d[ELEM_W]) begin
      r.value = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      r.value = {1'b0, {(ELEM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/lupp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Width and depth are parameters; no dependencies.
module lupp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lupp_div.sv
// Serial restoring divider of unsigned magnitudes, one quotient bit a cycle.
// Uses the sizes and request/response types of lupp_pkg.
module lupp_div (
  input  logic               clk,
  input  logic               rst,
  input  lupp_pkg::div_req_t req,
  output lupp_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(lupp_pkg::NUM_W);

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [lupp_pkg::ELEM_W:0]   rem;
  logic [lupp_pkg::NUM_W-1:0]  quo;
  logic [lupp_pkg::ELEM_W-1:0] dvs;
  logic [lupp_pkg::ELEM_W:0]   trial;
  logic                        ge;

  assign trial = {rem[lupp_pkg::ELEM_W-1:0], quo[lupp_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(lupp_pkg::NUM_W - 1);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? (trial - {1'b0, dvs}) : trial;
        quo <= {quo[lupp_pkg::NUM_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/lu_decomposition_partial_pivot_core.sv
// LU factorization core with partial pivoting: one RAM holds the matrix, a sequencer
// reads, modifies and writes it back. One command at a time; writes and permutation
// reads go from idle straight to the done state, element reads through a read-wait state.
// Factorizing: for each column k, a pivot search, a row and permutation swap when the
// pivot row differs, then a serial 48-bit divide per multiplier and row multiply-subtracts.
// Reset clears control, flags and permutation (identity), order 8; no RAM clearing.
module lu_decomposition_partial_pivot_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  lupp_pkg::cmd_t            cmd,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output lupp_pkg::rsp_t            rsp,
  input  logic                      cfg_write,
  input  logic [lupp_pkg::ORDER_W-1:0] cfg_data
);

  localparam int IW = lupp_pkg::IDX_W;
  localparam int EW = lupp_pkg::ELEM_W;
  localparam int OW = lupp_pkg::ORDER_W;

  lupp_pkg::state_t state, state_next;

  logic [OW-1:0]               order;
  logic [OW-1:0]               n;
  logic [IW-1:0]               k, i, j, best;
  logic [EW-1:0]               best_mag;
  logic signed [EW-1:0]        best_val, piv, tmp_a, f_reg, a_reg, p_reg, res;
  logic [lupp_pkg::PROD_W-1:0] prod;
  logic                        pneg, div_neg;
  logic [IW-1:0]               perm [lupp_pkg::MAX_ORDER];
  logic [IW-1:0]               ptmp;
  logic                        singular, overflow;

  logic                        accept, out_free;
  logic                        ram_we;
  logic [lupp_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic signed [EW-1:0]        ram_wdata, rd_data;
  logic [IW-1:0]               perm_ra, perm_rd;
  lupp_pkg::div_req_t          div_req;
  lupp_pkg::div_rsp_t          div_rsp;

  logic [EW-1:0]               rd_mag;
  logic                        take;
  logic [IW-1:0]               new_best;
  logic                        i_last, j_last, k_last;
  lupp_pkg::sat_t              fq, ps, ms;

  lupp_ram #(
    .WIDTH(EW),
    .DEPTH(lupp_pkg::MAX_ORDER * lupp_pkg::MAX_ORDER)
  ) u_mat (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  lupp_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign n        = (order == '0) ? OW'(1) :
                    (order > OW'(lupp_pkg::MAX_ORDER)) ? OW'(lupp_pkg::MAX_ORDER) : order;
  assign accept   = cmd_valid && !cmd_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign perm_rd  = perm[perm_ra];
  assign rd_mag   = lupp_pkg::magnitude(rd_data);
  assign take     = (i == k) || (rd_mag > best_mag);
  assign new_best = take ? i : best;
  assign i_last   = (OW'(i) + OW'(1)) == n;
  assign j_last   = (OW'(j) + OW'(1)) == n;
  assign k_last   = (OW'(k) + OW'(1)) == n;
  assign fq       = lupp_pkg::from_mag(div_neg, div_rsp.quotient);
  assign ps       = lupp_pkg::from_mag(pneg, prod[lupp_pkg::PROD_W-1:lupp_pkg::FRAC_W]);
  assign ms       = lupp_pkg::sat_sub(a_reg, p_reg);

  always_comb begin
    state_next = state;
    unique case (state)
      lupp_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd.func)
            lupp_pkg::FUNC_FACTOR: state_next = lupp_pkg::S_F_INIT;
            lupp_pkg::FUNC_READ:   state_next = lupp_pkg::S_RD_WAIT;
            default:               state_next = lupp_pkg::S_DONE;
          endcase
        end
      end
      lupp_pkg::S_RD_WAIT: state_next = lupp_pkg::S_DONE;
      lupp_pkg::S_DONE: begin
        if (out_free) begin
          state_next = lupp_pkg::S_IDLE;
        end
      end
      lupp_pkg::S_F_INIT:  state_next = lupp_pkg::S_PS_ADDR;
      lupp_pkg::S_PS_ADDR: state_next = lupp_pkg::S_PS_CMP;
      lupp_pkg::S_PS_CMP: begin
        if (!i_last) begin
          state_next = lupp_pkg::S_PS_ADDR;
        end else if (new_best != k) begin
          state_next = lupp_pkg::S_SW_RA;
        end else begin
          state_next = lupp_pkg::S_PIV;
        end
      end
      lupp_pkg::S_SW_RA: state_next = lupp_pkg::S_SW_RB;
      lupp_pkg::S_SW_RB: state_next = lupp_pkg::S_SW_W1;
      lupp_pkg::S_SW_W1: state_next = lupp_pkg::S_SW_W2;
      lupp_pkg::S_SW_W2: state_next = j_last ? lupp_pkg::S_PM1 : lupp_pkg::S_SW_RA;
      lupp_pkg::S_PM1:   state_next = lupp_pkg::S_PM2;
      lupp_pkg::S_PM2:   state_next = lupp_pkg::S_PIV;
      lupp_pkg::S_PIV: begin
        if (k_last) begin
          state_next = lupp_pkg::S_DONE;
        end else if (best_val == '0) begin
          state_next = lupp_pkg::S_ZERO;
        end else begin
          state_next = lupp_pkg::S_E_RD;
        end
      end
      lupp_pkg::S_ZERO:   state_next = i_last ? lupp_pkg::S_NEXT_K : lupp_pkg::S_ZERO;
      lupp_pkg::S_NEXT_K: state_next = lupp_pkg::S_PS_ADDR;
      lupp_pkg::S_E_RD:   state_next = lupp_pkg::S_E_DIV;
      lupp_pkg::S_E_DIV:  state_next = lupp_pkg::S_E_WAIT;
      lupp_pkg::S_E_WAIT: begin
        if (div_rsp.done) begin
          state_next = lupp_pkg::S_M_RA;
        end
      end
      lupp_pkg::S_M_RA:  state_next = lupp_pkg::S_M_RB;
      lupp_pkg::S_M_RB:  state_next = lupp_pkg::S_M_SAT;
      lupp_pkg::S_M_SAT: state_next = lupp_pkg::S_M_WR;
      lupp_pkg::S_M_WR: begin
        if (!j_last) begin
          state_next = lupp_pkg::S_M_RA;
        end else if (i_last) begin
          state_next = lupp_pkg::S_NEXT_K;
        end else begin
          state_next = lupp_pkg::S_E_RD;
        end
      end
      default: state_next = lupp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall        = state != lupp_pkg::S_IDLE;
    ram_we           = 1'b0;
    ram_waddr        = {i, k};
    ram_wdata        = '0;
    ram_raddr        = {i, k};
    perm_ra          = k;
    div_req.start    = 1'b0;
    div_req.dividend = {lupp_pkg::magnitude(rd_data), lupp_pkg::FRAC_W'(0)};
    div_req.divisor  = lupp_pkg::magnitude(piv);
    unique case (state)
      lupp_pkg::S_IDLE: begin
        ram_raddr = {cmd.row_index, cmd.col_index};
        perm_ra   = cmd.row_index;
        if (accept && cmd.func == lupp_pkg::FUNC_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = {cmd.row_index, cmd.col_index};
          ram_wdata = cmd.elem_value;
        end
      end
      lupp_pkg::S_SW_RA: ram_raddr = {k, j};
      lupp_pkg::S_SW_RB: ram_raddr = {best, j};
      lupp_pkg::S_SW_W1: begin
        ram_we    = 1'b1;
        ram_waddr = {k, j};
        ram_wdata = rd_data;
      end
      lupp_pkg::S_SW_W2: begin
        ram_we    = 1'b1;
        ram_waddr = {best, j};
        ram_wdata = tmp_a;
      end
      lupp_pkg::S_PM2: perm_ra = best;
      lupp_pkg::S_ZERO: begin
        ram_we = 1'b1;
      end
      lupp_pkg::S_E_DIV: div_req.start = 1'b1;
      lupp_pkg::S_E_WAIT: begin
        ram_we    = div_rsp.done;
        ram_wdata = fq.value;
      end
      lupp_pkg::S_M_RA: ram_raddr = {k, j};
      lupp_pkg::S_M_RB: ram_raddr = {i, j};
      lupp_pkg::S_M_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {i, j};
        ram_wdata = ms.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lupp_pkg::S_IDLE;
      order     <= lupp_pkg::ORDER_RESET;
      singular  <= 1'b0;
      overflow  <= 1'b0;
      rsp_valid <= 1'b0;
      for (int x = 0; x < lupp_pkg::MAX_ORDER; x++) begin
        perm[x] <= IW'(x);
      end
    end else begin
      state <= state_next;
      if (cfg_write) begin
        order <= cfg_data;
      end
      if (state == lupp_pkg::S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        lupp_pkg::S_F_INIT: begin
          singular <= 1'b0;
          overflow <= 1'b0;
          for (int x = 0; x < lupp_pkg::MAX_ORDER; x++) begin
            perm[x] <= IW'(x);
          end
        end
        lupp_pkg::S_PM2: begin
          perm[k]    <= perm_rd;
          perm[best] <= ptmp;
        end
        lupp_pkg::S_PIV: begin
          if (best_val == '0) begin
            singular <= 1'b1;
          end
        end
        lupp_pkg::S_E_WAIT: begin
          if (div_rsp.done) begin
            overflow <= overflow | fq.ovf;
          end
        end
        lupp_pkg::S_M_SAT: overflow <= overflow | ps.ovf;
        lupp_pkg::S_M_WR:  overflow <= overflow | ms.ovf;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == lupp_pkg::S_DONE && out_free) begin
      rsp.read_value    <= res;
      rsp.singular_flag <= singular;
      rsp.overflow_flag <= overflow;
    end
    unique case (state)
      lupp_pkg::S_IDLE: begin
        res <= (cmd.func == lupp_pkg::FUNC_PERM) ? EW'(perm_rd) : '0;
      end
      lupp_pkg::S_RD_WAIT: res <= rd_data;
      lupp_pkg::S_F_INIT: begin
        k <= '0;
        i <= '0;
      end
      lupp_pkg::S_PS_CMP: begin
        if (take) begin
          best     <= i;
          best_mag <= rd_mag;
          best_val <= rd_data;
        end
        i <= i + IW'(1);
        j <= '0;
      end
      lupp_pkg::S_SW_RB: tmp_a <= rd_data;
      lupp_pkg::S_SW_W2: j <= j + IW'(1);
      lupp_pkg::S_PM1:   ptmp <= perm_rd;
      lupp_pkg::S_PIV: begin
        piv <= best_val;
        i   <= k + IW'(1);
      end
      lupp_pkg::S_ZERO: i <= i + IW'(1);
      lupp_pkg::S_NEXT_K: begin
        k <= k + IW'(1);
        i <= k + IW'(1);
      end
      lupp_pkg::S_E_DIV: div_neg <= rd_data[EW-1] ^ piv[EW-1];
      lupp_pkg::S_E_WAIT: begin
        f_reg <= fq.value;
        j     <= k + IW'(1);
      end
      lupp_pkg::S_M_RB: begin
        prod <= lupp_pkg::PROD_W'(lupp_pkg::magnitude(f_reg)) *
                lupp_pkg::PROD_W'(lupp_pkg::magnitude(rd_data));
        pneg <= f_reg[EW-1] ^ rd_data[EW-1];
      end
      lupp_pkg::S_M_SAT: begin
        a_reg <= rd_data;
        p_reg <= ps.value;
      end
      lupp_pkg::S_M_WR: begin
        if (j_last) begin
          i <= i + IW'(1);
        end else begin
          j <= j + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != lupp_pkg::S_IDLE)
    else $error("command transfer did not start processing");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == lupp_pkg::S_E_WAIT)
    else $error("divider finished outside its wait state");

  a_pivot_row_range: assert property (@(posedge clk) disable iff (rst)
    state == lupp_pkg::S_PIV |-> (best >= k) && (OW'(best) < n))
    else $error("pivot row outside the active rows");

endmodule

// File: tb/tb_lu_decomposition_partial_pivot_core.sv
// Testbench for the LU decomposition core with partial pivoting: random and
// directed element writes, factorizations and reads, checked by a scoreboard.
// Depends on rtl/lupp_pkg.sv and rtl/lu_decomposition_partial_pivot_core.sv.
`timescale 1ns / 1ps

module tb_lu_decomposition_partial_pivot_core;
  import lupp_pkg::*;

  localparam longint EMAX = 64'sd2147483647;
  localparam longint EMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 1500000;

  class lu_scoreboard;
    longint mat[MAX_ORDER*MAX_ORDER];
    logic [IDX_W-1:0] perm[MAX_ORDER];
    bit sing;
    bit ovf;
    int order;
    rsp_t exp_q[$];
    int errors;

    function new();
      for (int i = 0; i < MAX_ORDER*MAX_ORDER; i++) mat[i] = 0;
      for (int i = 0; i < MAX_ORDER; i++) perm[i] = IDX_W'(i);
      order = 8;
      errors = 0;
    endfunction

    function void set_order(logic [ORDER_W-1:0] v);
      order = (v == 0) ? 1 : (v > MAX_ORDER) ? MAX_ORDER : int'(v);
    endfunction

    function longint rebuild(bit neg, longint unsigned m);
      longint unsigned lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > lim) begin
        ovf = 1;
        m = lim;
      end
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint fx_mult(longint a, longint b);
      longint unsigned ma, mb;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      return rebuild((a < 0) != (b < 0), (ma * mb) >> FRAC_W);
    endfunction

    function longint fx_quot(longint a, longint d);
      longint unsigned ma, md;
      ma = a < 0 ? -a : a;
      md = d < 0 ? -d : d;
      return rebuild((a < 0) != (d < 0), (ma << FRAC_W) / md);
    endfunction

    function longint fx_minus(longint a, longint b);
      longint d;
      d = a - b;
      if (d > EMAX) begin
        ovf = 1;
        return EMAX;
      end
      if (d < EMIN) begin
        ovf = 1;
        return EMIN;
      end
      return d;
    endfunction

    function void factorize();
      int best;
      longint unsigned bm, m;
      longint t, piv, f;
      logic [IDX_W-1:0] tp;
      sing = 0;
      ovf = 0;
      for (int i = 0; i < MAX_ORDER; i++) perm[i] = IDX_W'(i);
      for (int k = 0; k < order; k++) begin
        best = k;
        bm = mat[k*8+k] < 0 ? -mat[k*8+k] : mat[k*8+k];
        for (int i = k + 1; i < order; i++) begin
          m = mat[i*8+k] < 0 ? -mat[i*8+k] : mat[i*8+k];
          if (m > bm) begin
            bm = m;
            best = i;
          end
        end
        if (best != k) begin
          for (int j = 0; j < order; j++) begin
            t = mat[k*8+j];
            mat[k*8+j] = mat[best*8+j];
            mat[best*8+j] = t;
          end
          tp = perm[k];
          perm[k] = perm[best];
          perm[best] = tp;
        end
        piv = mat[k*8+k];
        if (piv == 0) begin
          sing = 1;
          for (int i = k + 1; i < order; i++) mat[i*8+k] = 0;
        end else begin
          for (int i = k + 1; i < order; i++) begin
            f = fx_quot(mat[i*8+k], piv);
            mat[i*8+k] = f;
            for (int j = k + 1; j < order; j++)
              mat[i*8+j] = fx_minus(mat[i*8+j], fx_mult(f, mat[k*8+j]));
          end
        end
      end
    endfunction

    function void note(cmd_t c);
      rsp_t r;
      r.read_value = 0;
      case (c.func)
        FUNC_WRITE:  mat[c.row_index*8+c.col_index] = c.elem_value;
        FUNC_FACTOR: factorize();
        FUNC_READ:   r.read_value = 32'(mat[c.row_index*8+c.col_index]);
        FUNC_PERM:   r.read_value = 32'(perm[c.row_index]);
      endcase
      r.singular_flag = sing;
      r.overflow_flag = ovf;
      exp_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check(rsp_t r);
      rsp_t e;
      if (exp_q.size() == 0) begin
        report("unexpected transfer", r.read_value, 0);
        return;
      end
      e = exp_q.pop_front();
      if (r.read_value !== e.read_value) report("read_value", r.read_value, e.read_value);
      if (r.singular_flag !== e.singular_flag)
        report("singular_flag", 32'(r.singular_flag), 32'(e.singular_flag));
      if (r.overflow_flag !== e.overflow_flag)
        report("overflow_flag", 32'(r.overflow_flag), 32'(e.overflow_flag));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cmd_valid = 0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;
  logic cfg_write = 0;
  logic [ORDER_W-1:0] cfg_data = '0;

  lu_scoreboard sb = new();
  int snd_pct = 0;
  int rcv_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;
  int n;

  lu_decomposition_partial_pivot_core u_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lu_decomposition_partial_pivot_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check(rsp);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return $urandom();
      default: return $urandom_range(8 << FRAC_W) - (4 << FRAC_W);
    endcase
  endfunction

  task send(func_t f, int r, int c, logic [31:0] v);
    while ($urandom_range(99) < snd_pct) begin
      cmd_valid <= 0;
      @(posedge clk);
    end
    cmd_valid <= 1;
    cmd <= '{func: f, row_index: IDX_W'(r), col_index: IDX_W'(c), elem_value: v};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note(cmd);
    sent++;
  endtask

  task drain_and_configure(logic [ORDER_W-1:0] v);
    cmd_valid <= 0;
    @(posedge clk);
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    sb.set_order(v);
  endtask

  task fill_factor_read(int zero_col);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        send(FUNC_WRITE, i, j, (j == zero_col) ? 32'd0 : pick_value());
    send(FUNC_FACTOR, 0, 0, $urandom());
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) send(FUNC_READ, i, j, $urandom());
    for (int i = 0; i < MAX_ORDER; i++) send(FUNC_PERM, i, 0, $urandom());
  endtask

  task random_item();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      send(FUNC_WRITE, $urandom_range(7), $urandom_range(7), pick_value());
    else if (r < 54)
      send(FUNC_FACTOR, $urandom_range(7), $urandom_range(7), $urandom());
    else if (r < 84)
      send(FUNC_READ, $urandom_range(7), $urandom_range(7), $urandom());
    else
      send(FUNC_PERM, $urandom_range(7), $urandom_range(7), $urandom());
  endtask

  logic [ORDER_W-1:0] orders[8] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd8};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < MAX_ORDER; i++)
      for (int j = 0; j < MAX_ORDER; j++) send(FUNC_WRITE, i, j, $urandom());
    for (int i = 0; i < MAX_ORDER; i++) send(FUNC_PERM, i, 0, 0);
    send(FUNC_WRITE, 0, 0, 32'h7fffffff);
    send(FUNC_WRITE, 7, 7, 32'h80000000);
    send(FUNC_READ, 7, 7, 32'hffffffff);
    send(FUNC_FACTOR, 7, 7, 0);
    send(FUNC_READ, 0, 0, 0);
    for (int i = 0; i < MAX_ORDER; i++) send(FUNC_PERM, i, 7, 0);
    for (int p = 0; p < 8; p++) begin
      drain_and_configure(orders[p]);
      n = sb.order;
      snd_pct = (p < 3) ? 27 : (p < 6) ? 47 : 0;
      rcv_pct = (p < 3) ? 47 : (p < 6) ? 27 : 0;
      if (p == 1) hold_left = 600;
      sent = 0;
      while (sent < 200) begin
        if ($urandom_range(9) == 0)
          fill_factor_read(($urandom_range(3) == 0) ? $urandom_range(n - 1) : -1);
        else
          random_item();
      end
    end
    cmd_valid <= 0;
    @(posedge clk);
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("PASS lu_decomposition_partial_pivot_core");
    end else begin
      $display("FAIL lu_decomposition_partial_pivot_core");
    end
    $finish;
  end

endmodule
